/* src/smash_pkg.sv */
// Package for the seeded multiply-add string hash.
// Holds widths, register reset values, register indexes and the front-to-queue struct.
// No dependencies.
package smash_pkg;

    localparam int HASH_W    = 64;   // running hash width, 32 to 64
    localparam int REG_W     = 64;   // configuration register width
    localparam int BUCKET_W  = 64;   // result width
    localparam int CHAR_W    = 8;
    localparam int SHIFT_AMT = 5;    // hash*33 = (hash << 5) + hash
    localparam int CNT_W     = $clog2(HASH_W);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [REG_W-1:0] SEED_RESET    = REG_W'(5381);
    localparam logic [REG_W-1:0] MODULUS_RESET = REG_W'(1024);

    localparam logic REG_SEED    = 1'b0;
    localparam logic REG_MODULUS = 1'b1;

    // one finished string hash handed from the front to the queue
    typedef struct packed {
        logic              push;
        logic [HASH_W-1:0] hash;
    } hash_xfer_t;

endpackage

/* src/smash_front.sv */
// Front end: accepts character transactions and updates the running hash.
// Depends on smash_pkg; hands finished hashes to the queue as smash_pkg::hash_xfer_t.
module smash_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [smash_pkg::CHAR_W-1:0]        char_byte,
    input  logic                                has_char,
    input  logic                                last,
    input  logic [smash_pkg::REG_W-1:0]         seed,
    output smash_pkg::hash_xfer_t               xfer
);

    logic [smash_pkg::HASH_W-1:0] running_hash_reg;
    logic [smash_pkg::HASH_W-1:0] running_hash_next;
    logic                         in_string_reg;
    logic                         in_string_next;
    logic [smash_pkg::HASH_W-1:0] h_base;
    logic [smash_pkg::HASH_W-1:0] c_ext;
    logic [smash_pkg::HASH_W-1:0] h_upd;

    assign h_base = in_string_reg ? running_hash_reg : seed[smash_pkg::HASH_W-1:0];
    // byte is a signed char
    assign c_ext  = smash_pkg::HASH_W'($signed(char_byte));
    assign h_upd  = (h_base << smash_pkg::SHIFT_AMT) + h_base + c_ext;

    always_comb
    begin
        running_hash_next = running_hash_reg;
        in_string_next    = in_string_reg;
        xfer.push         = 1'b0;
        xfer.hash         = has_char ? h_upd : h_base;
        if (accept)
        begin
            if (has_char)
            begin
                running_hash_next = h_upd;
                in_string_next    = 1'b1;
            end
            if (last)
            begin
                xfer.push      = 1'b1;
                in_string_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg <= 1'b0;
        end
        else
        begin
            in_string_reg <= in_string_next;
        end
    end

    always_ff @(posedge clk)
    begin
        running_hash_reg <= running_hash_next;
    end

endmodule

/* src/smash_fifo.sv */
// Short queue of finished string hashes between front and back.
// Depends on smash_pkg.
module smash_fifo
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  smash_pkg::hash_xfer_t         xfer,
    input  logic                          pop,
    output logic                          full,
    output logic                          not_empty,
    output logic [smash_pkg::HASH_W-1:0]  head
);

    logic [smash_pkg::HASH_W-1:0] entry_reg [smash_pkg::QDEPTH];
    logic [smash_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [smash_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [smash_pkg::QCNT_W-1:0] count_reg;
    logic [smash_pkg::QCNT_W-1:0] count_next;

    assign full      = (count_reg == smash_pkg::QCNT_W'(smash_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({xfer.push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (xfer.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer.push)
        begin
            entry_reg[wr_ptr_reg] <= xfer.hash;
        end
    end

endmodule

/* src/smash_back.sv */
// Back end: bit-serial restoring modulo of a finished hash, plus the output register.
// Depends on smash_pkg.
module smash_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_not_empty,
    input  logic [smash_pkg::HASH_W-1:0]    q_head,
    output logic                            q_pop,
    input  logic [smash_pkg::REG_W-1:0]     modulus,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [smash_pkg::BUCKET_W-1:0]  bucket
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [smash_pkg::CNT_W-1:0]    cnt_reg;
    logic [smash_pkg::CNT_W-1:0]    cnt_next;
    logic [smash_pkg::HASH_W-1:0]   dvd_reg;
    logic [smash_pkg::HASH_W-1:0]   dvd_next;
    logic [smash_pkg::REG_W-1:0]    rem_reg;
    logic [smash_pkg::REG_W-1:0]    rem_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [smash_pkg::BUCKET_W-1:0] bucket_reg;
    logic [smash_pkg::BUCKET_W-1:0] bucket_next;
    logic [smash_pkg::REG_W:0]      shifted;
    logic [smash_pkg::REG_W:0]      diff;
    logic                           out_free;

    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // remainder stays below modulus, so the shifted value fits REG_W+1 bits
    assign shifted = {rem_reg, dvd_reg[smash_pkg::HASH_W-1]};
    assign diff    = shifted - {1'b0, modulus};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        bucket_next    = bucket_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop    = 1'b1;
                    dvd_next = q_head;
                    cnt_next = '1;
                    if (modulus == '0)
                    begin
                        // zero modulus: hash goes out unreduced
                        rem_next   = smash_pkg::REG_W'(q_head);
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        rem_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                dvd_next = dvd_reg << 1;
                if (!diff[smash_pkg::REG_W])
                begin
                    rem_next = diff[smash_pkg::REG_W-1:0];
                end
                else
                begin
                    rem_next = shifted[smash_pkg::REG_W-1:0];
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    bucket_next    = smash_pkg::BUCKET_W'(rem_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        bucket_reg <= bucket_next;
    end

endmodule

/* src/seeded_multiply_add_string_hash.sv */
// Top level of the seeded multiply-add string hash.
// Depends on smash_pkg, smash_front, smash_fifo and smash_back.
//
// Streams a string one character transaction at a time and returns, for each
// transaction marked last, the 64-bit hash reduced modulo the modulus register.
// Each string starts from the seed register; every character updates the hash
// to hash*33 + sign-extended byte, wrapping at the hash width. The front takes
// one transaction per cycle while not stalled and does the multiply-add in that
// cycle. A finished hash goes into a two-entry queue; the back end reduces it
// with a bit-serial restoring divider, one bit per cycle (a zero modulus skips
// the reduction and returns the raw hash). The divider sets the string rate:
// strings as long as a reduction overlap fully, runs of shorter ones stall the
// input once the queue is full. in_stall is high exactly when the queue is
// full. A registered output stage lets the divider start the next string while
// a bucket waits to be taken. Configuration is written by the user through
// cfg_wr_en/cfg_index/cfg_data only while idle; the block does not enforce it.
// Index 0 is the seed (reset 5381), index 1 the modulus (reset 1024).
module seeded_multiply_add_string_hash
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [smash_pkg::REG_W-1:0]       cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [smash_pkg::CHAR_W-1:0]      char_byte,
    input  logic                              has_char,
    input  logic                              last,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [smash_pkg::BUCKET_W-1:0]    bucket
);

    logic [smash_pkg::REG_W-1:0]  seed_reg;
    logic [smash_pkg::REG_W-1:0]  modulus_reg;
    smash_pkg::hash_xfer_t        xfer;
    logic                         q_full;
    logic                         q_not_empty;
    logic                         q_pop;
    logic [smash_pkg::HASH_W-1:0] q_head;
    logic                         in_accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= smash_pkg::SEED_RESET;
            modulus_reg <= smash_pkg::MODULUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                smash_pkg::REG_SEED:    seed_reg    <= cfg_data;
                smash_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                default:                seed_reg    <= seed_reg;
            endcase
        end
    end

    // a full queue holds off every transaction, so a last one always has room
    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    smash_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .char_byte (char_byte),
        .has_char  (has_char),
        .last      (last),
        .seed      (seed_reg),
        .xfer      (xfer)
    );

    smash_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .xfer      (xfer),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    smash_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .modulus     (modulus_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bucket      (bucket)
    );

endmodule

/* sim/tb_seeded_multiply_add_string_hash.sv */
// Self-checking testbench for seeded_multiply_add_string_hash.
// Depends on smash_pkg and the block's RTL. Streams directed and random strings
// through the character channel, predicts each bucket and checks the results in order.
module tb_seeded_multiply_add_string_hash;

    // Allowance for the divider, the two-entry queue and the output register,
    // once the last expected bucket has come.
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_PCT     = 28;

    // One character transaction as the sender sees it.
    typedef struct packed {
        logic [smash_pkg::CHAR_W-1:0] ch;
        logic                         has_ch;
        logic                         ends;
    } char_txn_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic                           cfg_index = smash_pkg::REG_SEED;
    logic [smash_pkg::REG_W-1:0]    cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [smash_pkg::CHAR_W-1:0]   char_byte = '0;
    logic                           has_char  = 1'b0;
    logic                           last      = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [smash_pkg::BUCKET_W-1:0] bucket;

    // Set for one whole phase: neither side idles or stalls while it is high.
    logic steady = 1'b0;
    int   errors = 0;

    char_txn_t                      pending_chars[$];
    logic [smash_pkg::BUCKET_W-1:0] expected_buckets[$];

    // Shadow of the configuration registers and of the string state.
    logic [smash_pkg::REG_W-1:0]  seed_reg   = smash_pkg::SEED_RESET;
    logic [smash_pkg::REG_W-1:0]  mod_reg    = smash_pkg::MODULUS_RESET;
    logic [smash_pkg::HASH_W-1:0] run_hash   = smash_pkg::SEED_RESET[smash_pkg::HASH_W-1:0];
    logic                         mid_string = 1'b0;

    seeded_multiply_add_string_hash DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_byte (char_byte),
        .has_char  (has_char),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bucket    (bucket)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Folds one accepted transaction into the running hash; a transaction marked
    // last queues the bucket it must produce and rearms the string from the seed.
    // A seed written mid-string only takes effect once that string has finished.
    function automatic void fold_char(input char_txn_t t);
        logic [smash_pkg::HASH_W-1:0] h;
        logic [smash_pkg::HASH_W-1:0] c;
        h = mid_string ? run_hash : seed_reg[smash_pkg::HASH_W-1:0];
        if (t.has_ch)
        begin
            // signed char, sign-extended to the hash width
            c = {{(smash_pkg::HASH_W-smash_pkg::CHAR_W){t.ch[smash_pkg::CHAR_W-1]}}, t.ch};
            h = (h << 5) + h + c;
            run_hash   = h;
            mid_string = 1'b1;
        end
        if (t.ends)
        begin
            // a zero modulus returns the hash unreduced
            if (mod_reg != '0)
                expected_buckets.push_back(
                    smash_pkg::BUCKET_W'(smash_pkg::REG_W'(h) % mod_reg));
            else
                expected_buckets.push_back(smash_pkg::BUCKET_W'(h));
            mid_string = 1'b0;
            run_hash   = seed_reg[smash_pkg::HASH_W-1:0];
        end
    endfunction

    // Sender. A new transaction is only loaded once the current one has been
    // taken, so a stalled payload holds; whether to idle is decided without
    // looking at in_stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                fold_char('{ch: char_byte, has_ch: has_char, ends: last});
            if (!in_valid || !in_stall)
            begin
                if (pending_chars.size() != 0
                    && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    char_txn_t t;
                    t = pending_chars.pop_front();
                    in_valid  <= 1'b1;
                    char_byte <= t.ch;
                    has_char  <= t.has_ch;
                    last      <= t.ends;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, and every accepted bucket is checked
    // against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
            if (out_valid && !out_stall)
            begin
                if (expected_buckets.size() == 0)
                begin
                    $display("%0t: unexpected bucket, expected none, got %h", $time, bucket);
                    errors++;
                end
                else
                begin
                    logic [smash_pkg::BUCKET_W-1:0] want;
                    want = expected_buckets.pop_front();
                    if (bucket !== want)
                    begin
                        $display("%0t: bucket mismatch, expected %h, got %h",
                                 $time, want, bucket);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic void push_char(input logic [smash_pkg::CHAR_W-1:0] ch,
                                      input logic has_ch, input logic ends);
        pending_chars.push_back('{ch: ch, has_ch: has_ch, ends: ends});
    endfunction

    // Random strings: mostly short, a few long, some empty; the ending comes
    // either with the final character or as a bare marker. Stray markers with no
    // character are sprinkled in and do not count.
    task automatic queue_strings(input int n);
        int   done;
        int   len;
        logic char_on_last;
        done = 0;
        while (done < n)
        begin
            if ($urandom_range(99) < 10)
            begin
                push_char(smash_pkg::CHAR_W'($urandom), 1'b0, 1'b1);
                done++;
            end
            else
            begin
                len = ($urandom_range(99) < 10) ? $urandom_range(48, 13)
                                                : $urandom_range(12, 1);
                char_on_last = 1'($urandom_range(1));
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(99) < 8)
                        push_char(smash_pkg::CHAR_W'($urandom), 1'b0, 1'b0);
                    push_char(smash_pkg::CHAR_W'($urandom), 1'b1,
                              char_on_last && (i == len - 1));
                    done++;
                end
                if (!char_on_last)
                begin
                    push_char(smash_pkg::CHAR_W'($urandom), 1'b0, 1'b1);
                    done++;
                end
            end
        end
    endtask

    // Waits until every transaction has been taken and every bucket has come,
    // then lets the block run dry. Checked on the falling edge, clear of the
    // sender's and receiver's updates.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_chars.size() != 0 || in_valid || expected_buckets.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Both registers, on back-to-back edges; the block is idle meanwhile.
    task automatic write_regs(input logic [smash_pkg::REG_W-1:0] s,
                              input logic [smash_pkg::REG_W-1:0] m);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= smash_pkg::REG_SEED;
        cfg_data  <= s;
        @(posedge clk);
        cfg_index <= smash_pkg::REG_MODULUS;
        cfg_data  <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        seed_reg = s;
        mod_reg  = m;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, at the reset seed and modulus.
        push_char(8'h00, 1'b0, 1'b1);           // empty string: seed mod modulus
        push_char(8'h5a, 1'b0, 1'b0);           // bare marker, ignored
        push_char(8'h41, 1'b1, 1'b1);           // character on the last transaction
        push_char(8'h00, 1'b1, 1'b0);           // byte extremes, both signs
        push_char(8'h7f, 1'b1, 1'b0);
        push_char(8'h80, 1'b1, 1'b0);
        push_char(8'hff, 1'b1, 1'b0);
        push_char(8'h00, 1'b0, 1'b1);           // ending as a bare marker
        push_char(8'h55, 1'b1, 1'b0);
        push_char(8'haa, 1'b0, 1'b0);           // marker inside a string
        push_char(8'h33, 1'b1, 1'b1);
        for (int i = 0; i < 12; i++)            // long enough to wrap the hash
            push_char(8'hfe, 1'b1, 1'b0);
        push_char(8'h01, 1'b1, 1'b1);
        settle();

        // Register extremes: zero seed with the widest modulus, then all-ones seed
        // with a modulus of one.
        write_regs('0, '1);
        queue_strings(200);
        settle();
        write_regs('1, smash_pkg::REG_W'(1));
        queue_strings(150);
        settle();

        // Zero modulus: the raw hash comes out.
        write_regs({$urandom, $urandom}, '0);
        queue_strings(150);
        settle();

        // Small modulus, with no idling or back-pressure on either side.
        write_regs({$urandom, $urandom}, smash_pkg::REG_W'($urandom_range(1000, 1)));
        steady = 1'b1;
        queue_strings(250);
        settle();
        steady = 1'b0;

        // Large modulus; the phase ends with a string left open so that the
        // seed below is written mid-string and must not touch it.
        write_regs(smash_pkg::SEED_RESET, {1'b1, 31'($urandom), 32'($urandom)});
        queue_strings(250);
        push_char(8'h61, 1'b1, 1'b0);
        push_char(8'hc3, 1'b1, 1'b0);
        settle();
        write_regs({$urandom, $urandom}, {1'b1, {(smash_pkg::REG_W-1){1'b0}}});
        queue_strings(200);
        settle();

        write_regs({$urandom, $urandom}, smash_pkg::REG_W'($urandom));
        queue_strings(150);
        settle();

        if (errors == 0)
            $display("tb_seeded_multiply_add_string_hash OK");
        else
            $display("tb_seeded_multiply_add_string_hash NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("tb_seeded_multiply_add_string_hash NOT OK");
        $finish;
    end

endmodule

/* files.f */
src/smash_pkg.sv
src/smash_front.sv
src/smash_fifo.sv
src/smash_back.sv
src/seeded_multiply_add_string_hash.sv
sim/tb_seeded_multiply_add_string_hash.sv
